FILE: hdl/soundex_encoder_core_defines.svh
// shared assertion macros, clocked on clk with asynchronous reset arst_n
`ifndef SOUNDEX_ENCODER_CORE_DEFINES_SVH
`define SOUNDEX_ENCODER_CORE_DEFINES_SVH

// same-cycle implication
`define SDX_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sdx assertion failed");

// next-cycle implication
`define SDX_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sdx assertion failed");

`endif

FILE: hdl/sdx_pkg.sv
package sdx_pkg;

	localparam int CODE_DIGITS = 3;
	localparam int DIGIT_CNT_W = 2;
	localparam int DIGIT_W = 3;
	localparam logic [7:0] CASE_GAP = 8'd32;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
	localparam logic [7:0] MAX_CODE_CHAR = 8'h36;

	typedef logic [DIGIT_W-1:0] digit_t;

	// case-folded soundex digit, 0 for anything outside the groups
	function automatic digit_t digit_of(input logic [7:0] c);
		logic [7:0] u;
		digit_t d;
		u = c;
		if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
			u = c - CASE_GAP;
		end
		case (u)
			"B", "F", "P", "V": d = digit_t'(1);
			"C", "G", "J", "K", "Q", "S", "X", "Z": d = digit_t'(2);
			"D", "T": d = digit_t'(3);
			"L": d = digit_t'(4);
			"M", "N": d = digit_t'(5);
			"R": d = digit_t'(6);
			default: d = digit_t'(0);
		endcase
		return d;
	endfunction

endpackage

FILE: hdl/soundex_encoder_core.sv
// Soundex encoder: takes one character per request, end_of_name on the last
// character of a name, and returns the code as requests on the output side
// (first character, then up to three digits, padded with '0', last_of_run on
// the final one). A character that yields at most one result is taken every
// cycle while the output accepts. A character that ends a name and needs
// padding yields up to four results; the output register drains them one per
// cycle while out_ready is high, and the input stalls meanwhile. A character
// passes through the input register, then the result register.
module soundex_encoder_core import sdx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] character,
	input  logic       end_of_name,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] code_char,
	output logic       last_of_run
);

	logic                   valid_s1;
	logic [7:0]             char_s1;
	logic                   end_s1;

	logic [7:0]             prev_q;
	logic [DIGIT_CNT_W-1:0] digits_q;
	logic                   start_q;

	logic                   head_valid_s2;
	logic [7:0]             head_char_s2;
	logic                   head_last_s2;
	logic [DIGIT_CNT_W-1:0] pad_s2;

	logic                   load_ok;
	logic                   advance;
	digit_t                 dig_cur;
	digit_t                 dig_prev;
	logic                   case_pair;
	logic                   emit;
	logic [7:0]             emit_char;
	logic                   emit_last;
	logic [DIGIT_CNT_W-1:0] digits_next;
	logic [DIGIT_CNT_W-1:0] pad_next;

	// output stage can take a new item when it is empty or empties this cycle
	assign load_ok = (!head_valid_s2 && pad_s2 == '0)
		|| (out_ready && ((head_valid_s2 && pad_s2 == '0)
		|| (!head_valid_s2 && pad_s2 == DIGIT_CNT_W'(1))));
	assign advance  = valid_s1 && load_ok;
	assign in_ready = !valid_s1 || load_ok;

	assign dig_cur   = digit_of(char_s1);
	assign dig_prev  = digit_of(prev_q);
	assign case_pair = ({1'b0, char_s1} == {1'b0, prev_q} + {1'b0, CASE_GAP})
		|| ({1'b0, prev_q} == {1'b0, char_s1} + {1'b0, CASE_GAP});

	always_comb begin
		emit        = 1'b0;
		emit_char   = char_s1;
		emit_last   = 1'b0;
		digits_next = digits_q;
		if (start_q) begin
			emit        = 1'b1;
			digits_next = '0;
		end else if (digits_q < DIGIT_CNT_W'(CODE_DIGITS)) begin
			if (dig_cur != '0 && (dig_cur != dig_prev || case_pair)) begin
				emit        = 1'b1;
				digits_next = digits_q + DIGIT_CNT_W'(1);
				emit_char   = ASCII_ZERO + {{(8-DIGIT_W){1'b0}}, dig_cur};
				emit_last   = (digits_next >= DIGIT_CNT_W'(CODE_DIGITS));
			end
		end
		pad_next = end_s1 ? (DIGIT_CNT_W'(CODE_DIGITS) - digits_next) : '0;
	end

	assign out_valid   = head_valid_s2 || pad_s2 != '0;
	assign code_char   = head_valid_s2 ? head_char_s2 : ASCII_ZERO;
	assign last_of_run = head_valid_s2 ? head_last_s2 : (pad_s2 == DIGIT_CNT_W'(1));

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= character;
			end_s1  <= end_of_name;
		end
	end

	// name state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			digits_q <= '0;
			start_q  <= 1'b1;
		end else if (advance) begin
			prev_q   <= char_s1;
			digits_q <= end_s1 ? '0 : digits_next;
			start_q  <= end_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_s2 <= 1'b0;
			pad_s2        <= '0;
		end else if (advance) begin
			head_valid_s2 <= emit;
			pad_s2        <= pad_next;
		end else if (out_valid && out_ready) begin
			if (head_valid_s2) begin
				head_valid_s2 <= 1'b0;
			end else begin
				pad_s2 <= pad_s2 - DIGIT_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			head_char_s2 <= emit_char;
			head_last_s2 <= emit_last;
		end
	end

endmodule

FILE: hdl/sdx_checker.sv
`include "soundex_encoder_core_defines.svh"

module sdx_checker import sdx_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] character,
	input logic       end_of_name,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] code_char,
	input logic       last_of_run
);

	// a stalled input request holds
	`SDX_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(character) && $stable(end_of_name))

	// a stalled output request holds
	`SDX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(code_char) && $stable(last_of_run))

	// input only stalls while a result is waiting
	`SDX_ASSERT_NOW(a_stall_has_result, !in_ready, out_valid)

	// the closing character of a code is a digit or padding
	`SDX_ASSERT_NOW(a_last_is_digit, out_valid && last_of_run, code_char >= ASCII_ZERO && code_char <= MAX_CODE_CHAR)

endmodule

bind soundex_encoder_core sdx_checker u_sdx_checker (.*);
